// ----- hdl/dwpi_pkg.sv -----
package dwpi_pkg;

  // sizes that the design may be built at
  localparam int ACC_W           = 40;
  localparam int STEER_ROM_DEPTH = 2048;
  localparam int ROM_AW          = $clog2(STEER_ROM_DEPTH);

  // field and register widths
  localparam int PEDAL_W   = 10;
  localparam int STEER_W   = 11;
  localparam int SPEED_W   = 14;
  localparam int SPD_LIM_W = 14;
  localparam int RATIO_W   = 17;
  localparam int COEF_W    = 24;
  localparam int LIMIT_W   = 10;
  localparam int GAIN_W    = 20;
  localparam int DUTY_W    = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // datapath widths
  localparam int Q16        = 16;
  localparam int TAN_W      = 17;
  localparam int BASE_W     = SPD_LIM_W + PEDAL_W;
  localparam int DPROD_W    = RATIO_W + 1 + TAN_W;
  localparam int DELTA_W    = DPROD_W - Q16;
  localparam int FACTOR_W   = DELTA_W + 1;
  localparam int TGT_PROD_W = BASE_W + 1 + FACTOR_W;
  localparam int MAG_W      = TGT_PROD_W - 1 - Q16;
  localparam int Q_W        = MAG_W - 9;
  localparam int TGT_W      = Q_W + 1;
  localparam int ERR_W      = TGT_W + 1;
  localparam int PI_PROD_W  = COEF_W + ERR_W;
  localparam int SUM_W      = ((ACC_W > PI_PROD_W) ? ACC_W : PI_PROD_W) + 2;
  localparam int CLAMP_W    = LIMIT_W + Q16;
  localparam int MUL_W      = 30;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DUTY_SHIFT = 32;
  localparam int DUTY_Q_W   = CLAMP_W + GAIN_W - DUTY_SHIFT;

  // constants of the control law
  localparam int CENTRE_CODE  = 900;
  localparam int TAN_CODE_MAX = 2047;
  localparam int ANGLE_STEP   = 451156;
  localparam int PEDAL_FULL   = 1000;
  localparam int ONE_Q16      = 65536;
  localparam int DUTY_MAX     = 255;
  // floor(m / 1000) == (m * RECIP_1000) >> RECIP_SHIFT for every m below 2^MAG_W
  localparam int RECIP_SHIFT  = 38;
  localparam logic signed [MUL_W-1:0] RECIP_1000 = MUL_W'(274877907);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_RATIO = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CURRENT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREVIOUS  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN      = CFG_IDX_W'(5);

  // register reset values
  localparam logic [SPD_LIM_W-1:0]     SPEED_LIMIT_RST = SPD_LIM_W'(5000);
  localparam logic [RATIO_W-1:0]       RATIO_RST       = RATIO_W'(40632);
  localparam logic signed [COEF_W-1:0] COEF_CUR_RST    = COEF_W'(12236);
  localparam logic signed [COEF_W-1:0] COEF_PREV_RST   = -COEF_W'(11234);
  localparam logic [LIMIT_W-1:0]       OUT_LIMIT_RST   = LIMIT_W'(102);
  localparam logic [GAIN_W-1:0]        DUTY_GAIN_RST   = GAIN_W'(63604);

  typedef enum logic [3:0] {
    L_IDLE,
    L_TGT,
    L_ABS,
    L_DIV,
    L_ERR,
    L_MC,
    L_MP,
    L_SUM,
    L_CLAMP,
    L_DUTY,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic                       valid;
    logic [BASE_W-1:0]          base;
    logic signed [FACTOR_W-1:0] factor_left;
    logic signed [FACTOR_W-1:0] factor_right;
  } split_res_t;

  typedef struct packed {
    logic                       start;
    logic [BASE_W-1:0]          base;
    logic signed [FACTOR_W-1:0] factor;
    logic [SPEED_W-1:0]         meas;
  } lane_cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_cur;
    logic signed [COEF_W-1:0] coef_prev;
    logic [LIMIT_W-1:0]       out_limit;
    logic [GAIN_W-1:0]        duty_gain;
  } pi_cfg_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] duty;
    logic              clamped;
  } lane_res_t;

  // tangent of the steering angle in signed Q16, sin and cos from Taylor series in Q30
  function automatic logic signed [TAN_W-1:0] tan_of_code(input int code);
    int          cd;
    int          i;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t3;
    logic [63:0] t5;
    logic [63:0] t7;
    logic [63:0] t9;
    logic [63:0] s;
    logic [63:0] c2;
    logic [63:0] c4;
    logic [63:0] c6;
    logic [63:0] c8;
    logic [63:0] c10;
    logic [63:0] c;
    logic [63:0] num;
    logic [63:0] r;
    logic [63:0] rem;
    cd = (code > TAN_CODE_MAX) ? TAN_CODE_MAX : code;
    neg = (cd < CENTRE_CODE);
    mag = neg ? 64'(CENTRE_CODE - cd) : 64'(cd - CENTRE_CODE);
    x   = mag * 64'(ANGLE_STEP);
    x2  = (x * x) >> 30;
    t3  = ((x * x2) >> 30) / 64'd6;
    t5  = ((t3 * x2) >> 30) / 64'd20;
    t7  = ((t5 * x2) >> 30) / 64'd42;
    t9  = ((t7 * x2) >> 30) / 64'd72;
    s   = x + t5 + t9 - t3 - t7;
    c2  = x2 >> 1;
    c4  = ((c2 * x2) >> 30) / 64'd12;
    c6  = ((c4 * x2) >> 30) / 64'd30;
    c8  = ((c6 * x2) >> 30) / 64'd56;
    c10 = ((c8 * x2) >> 30) / 64'd90;
    c   = (64'd1 << 30) + c4 + c8 - c2 - c6 - c10;
    num = (s << Q16) + (c >> 1);
    // restoring division, rounded to nearest through the half divisor above
    r   = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= c) begin
        rem  = rem - c;
        r[i] = 1'b1;
      end
    end
    return neg ? -$signed(r[TAN_W-1:0]) : $signed(r[TAN_W-1:0]);
  endfunction

endpackage

// ----- hdl/dual_wheel_pi_speed_control_core.sv -----
// Speed controller for two wheel motors with an electronic differential.
// Input channel (in_valid/in_ready) carries one control tick: pedal, steering
// code and the two measured motor speeds. Result channel (out_valid/out_ready)
// returns one item per tick: a duty value and a clamp flag for each wheel.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no tick is in flight, which the block
// itself does not enforce. Indexes with no register are ignored. A new tick is
// taken only after the result of the last one is parked in the output register.
// Each wheel has one multiplier, which works out target, divide by 1000, both
// PI products and duty scale in turn, after the steering ROM read and split.
// Both wheels run side by side in identical lanes and finish together.
// If the receiver stalls, the result waits in the output register; the next
// tick is still accepted and computed, then held in the lanes until the
// output register frees up.
// Reset (synchronous, rst_n low) restores the register defaults and clears
// both integrators and stored errors.
module dual_wheel_pi_speed_control_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dwpi_pkg::PEDAL_W-1:0]      in_pedal,
  input  logic [dwpi_pkg::STEER_W-1:0]      in_steering,
  input  logic [dwpi_pkg::SPEED_W-1:0]      in_speed_left,
  input  logic [dwpi_pkg::SPEED_W-1:0]      in_speed_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dwpi_pkg::DUTY_W-1:0]       out_duty_left,
  output logic [dwpi_pkg::DUTY_W-1:0]       out_duty_right,
  output logic                              out_left_clamped,
  output logic                              out_right_clamped,
  input  logic                              cfg_we,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwpi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dwpi_pkg::*;

  logic [SPD_LIM_W-1:0]     speed_limit_r;
  logic [RATIO_W-1:0]       ratio_r;
  logic signed [COEF_W-1:0] coef_cur_r;
  logic signed [COEF_W-1:0] coef_prev_r;
  logic [LIMIT_W-1:0]       out_limit_r;
  logic [GAIN_W-1:0]        duty_gain_r;

  logic               accept;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               merge_fire;
  logic [SPEED_W-1:0] speed_l_r;
  logic [SPEED_W-1:0] speed_r_r;
  logic [DUTY_W-1:0]  duty_l_r;
  logic [DUTY_W-1:0]  duty_r_r;
  logic               clamp_l_r;
  logic               clamp_r_r;

  split_res_t split_res;
  lane_cmd_t  cmd_l;
  lane_cmd_t  cmd_r;
  pi_cfg_t    pi_cfg;
  lane_res_t  res_l;
  lane_res_t  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= SPEED_LIMIT_RST;
      ratio_r       <= RATIO_RST;
      coef_cur_r    <= COEF_CUR_RST;
      coef_prev_r   <= COEF_PREV_RST;
      out_limit_r   <= OUT_LIMIT_RST;
      duty_gain_r   <= DUTY_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_LIMIT:    speed_limit_r <= cfg_wdata[SPD_LIM_W-1:0];
        REG_GEOMETRY_RATIO: ratio_r       <= cfg_wdata[RATIO_W-1:0];
        REG_COEF_CURRENT:   coef_cur_r    <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_COEF_PREVIOUS:  coef_prev_r   <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_OUTPUT_LIMIT:   out_limit_r   <= cfg_wdata[LIMIT_W-1:0];
        REG_DUTY_GAIN:      duty_gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;

  dwpi_split u_split (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (accept),
    .pedal          (in_pedal),
    .steering       (in_steering),
    .speed_limit    (speed_limit_r),
    .geometry_ratio (ratio_r),
    .res            (split_res)
  );

  assign pi_cfg.coef_cur  = coef_cur_r;
  assign pi_cfg.coef_prev = coef_prev_r;
  assign pi_cfg.out_limit = out_limit_r;
  assign pi_cfg.duty_gain = duty_gain_r;

  assign cmd_l.start  = split_res.valid;
  assign cmd_l.base   = split_res.base;
  assign cmd_l.factor = split_res.factor_left;
  assign cmd_l.meas   = speed_l_r;

  assign cmd_r.start  = split_res.valid;
  assign cmd_r.base   = split_res.base;
  assign cmd_r.factor = split_res.factor_right;
  assign cmd_r.meas   = speed_r_r;

  dwpi_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_l),
    .cfg   (pi_cfg),
    .ack   (merge_fire),
    .res   (res_l)
  );

  dwpi_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_r),
    .cfg   (pi_cfg),
    .ack   (merge_fire),
    .res   (res_r)
  );

  // both lanes done and output register free (or being emptied this cycle)
  assign merge_fire = res_l.done && res_r.done && (!out_valid_r || out_ready);

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (merge_fire) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (merge_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      speed_l_r <= in_speed_left;
      speed_r_r <= in_speed_right;
    end
    if (merge_fire) begin
      duty_l_r  <= res_l.duty;
      duty_r_r  <= res_r.duty;
      clamp_l_r <= res_l.clamped;
      clamp_r_r <= res_r.clamped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duty_left     = duty_l_r;
  assign out_duty_right    = duty_r_r;
  assign out_left_clamped  = clamp_l_r;
  assign out_right_clamped = clamp_r_r;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    res_l.done |-> res_r.done)
    else $error("wheel lanes out of step");

  a_split_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    split_res.valid |-> busy_r)
    else $error("split result with no tick in flight");

  a_merge_frees: assert property (@(posedge clk) disable iff (!rst_n)
    merge_fire |=> (out_valid_r && !busy_r))
    else $error("merge did not load output or release the input side");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && !res_l.done && !split_res.valid))
    else $error("transfer accepted while lanes still held a result");

endmodule

// ----- hdl/dwpi_rom.sv -----
module dwpi_rom (
  input  logic                               clk,
  input  logic [dwpi_pkg::ROM_AW-1:0]        addr,
  output logic signed [dwpi_pkg::TAN_W-1:0]  data_r
);
  import dwpi_pkg::*;

  logic signed [TAN_W-1:0] rom_w [STEER_ROM_DEPTH];

  for (genvar g = 0; g < STEER_ROM_DEPTH; g++) begin : g_entry
    localparam logic signed [TAN_W-1:0] ENTRY = tan_of_code(g);
    assign rom_w[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

// ----- hdl/dwpi_split.sv -----
module dwpi_split (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [dwpi_pkg::PEDAL_W-1:0]      pedal,
  input  logic [dwpi_pkg::STEER_W-1:0]      steering,
  input  logic [dwpi_pkg::SPD_LIM_W-1:0]    speed_limit,
  input  logic [dwpi_pkg::RATIO_W-1:0]      geometry_ratio,
  output dwpi_pkg::split_res_t              res
);
  import dwpi_pkg::*;

  logic [2:0]                 vld_r;
  logic [ROM_AW-1:0]          rom_addr;
  logic signed [TAN_W-1:0]    tan_q;
  logic [PEDAL_W-1:0]         pedal_sat;
  logic [BASE_W-1:0]          base_r;
  logic signed [DPROD_W-1:0]  dprod_r;
  logic signed [DELTA_W-1:0]  delta;
  logic                       round_up;
  logic signed [FACTOR_W-1:0] fac_l_r;
  logic signed [FACTOR_W-1:0] fac_r_r;

  assign pedal_sat = (pedal > PEDAL_W'(PEDAL_FULL)) ? PEDAL_W'(PEDAL_FULL) : pedal;
  assign rom_addr  = (int'(steering) >= STEER_ROM_DEPTH) ? ROM_AW'(STEER_ROM_DEPTH - 1)
                                                         : ROM_AW'(steering);

  dwpi_rom u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (tan_q)
  );

  // shift towards zero, as a signed division does
  assign round_up = dprod_r[DPROD_W-1] && (dprod_r[Q16-1:0] != '0);
  assign delta    = $signed(dprod_r[DPROD_W-1:Q16]) +
                    $signed({{(DELTA_W-1){1'b0}}, round_up});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_r <= BASE_W'(speed_limit) * BASE_W'(pedal_sat);
    end
    if (vld_r[0]) begin
      dprod_r <= DPROD_W'($signed({1'b0, geometry_ratio})) * DPROD_W'(tan_q);
    end
    if (vld_r[1]) begin
      fac_l_r <= FACTOR_W'(ONE_Q16) + FACTOR_W'(delta);
      fac_r_r <= FACTOR_W'(ONE_Q16) - FACTOR_W'(delta);
    end
  end

  assign res.valid        = vld_r[2];
  assign res.base         = base_r;
  assign res.factor_left  = fac_l_r;
  assign res.factor_right = fac_r_r;

endmodule

// ----- hdl/dwpi_lane.sv -----
module dwpi_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dwpi_pkg::lane_cmd_t  cmd,
  input  dwpi_pkg::pi_cfg_t    cfg,
  input  logic                 ack,
  output dwpi_pkg::lane_res_t  res
);
  import dwpi_pkg::*;

  localparam logic signed [SUM_W-1:0] ACC_MAX_EXT =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_EXT =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  lane_state_t state_r, state_nxt;

  logic [BASE_W-1:0]          base_r;
  logic signed [FACTOR_W-1:0] factor_r;
  logic [SPEED_W-1:0]         meas_r;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic                       mul_en;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_abs;
  logic                       neg_r;
  logic [MAG_W-1:0]           mag_r;
  logic [Q_W-1:0]             quot;
  logic signed [TGT_W-1:0]    quot_s;
  logic signed [TGT_W-1:0]    tgt;
  logic signed [ERR_W-1:0]    err_calc;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [ERR_W-1:0]    pe_r;
  logic signed [ACC_W-1:0]    po_r;
  logic signed [SUM_W-1:0]    pi_term;
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SUM_W-1:0]    sum;
  logic signed [ACC_W-1:0]    po_sat;
  logic signed [SUM_W-1:0]    po_ext;
  logic signed [SUM_W-1:0]    lim_ext;
  logic [CLAMP_W-1:0]         lim;
  logic [CLAMP_W-1:0]         clamp_r;
  logic                       clamped_r;
  logic [DUTY_Q_W-1:0]        duty_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one multiplier, shared by the five products of an item
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_en    = 1'b0;
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          state_nxt = L_TGT;
        end
      end
      L_TGT: begin
        mul_a     = MUL_W'($signed({1'b0, base_r}));
        mul_b     = MUL_W'(factor_r);
        mul_en    = 1'b1;
        state_nxt = L_ABS;
      end
      L_ABS: begin
        state_nxt = L_DIV;
      end
      L_DIV: begin
        mul_a     = MUL_W'($signed({1'b0, mag_r}));
        mul_b     = RECIP_1000;
        mul_en    = 1'b1;
        state_nxt = L_ERR;
      end
      L_ERR: begin
        state_nxt = L_MC;
      end
      L_MC: begin
        mul_a     = MUL_W'(err_r);
        mul_b     = MUL_W'($signed(cfg.coef_cur));
        mul_en    = 1'b1;
        state_nxt = L_MP;
      end
      L_MP: begin
        mul_a     = MUL_W'(pe_r);
        mul_b     = MUL_W'($signed(cfg.coef_prev));
        mul_en    = 1'b1;
        state_nxt = L_SUM;
      end
      L_SUM: begin
        state_nxt = L_CLAMP;
      end
      L_CLAMP: begin
        state_nxt = L_DUTY;
      end
      L_DUTY: begin
        mul_a     = MUL_W'($signed({1'b0, clamp_r}));
        mul_b     = MUL_W'($signed({1'b0, cfg.duty_gain}));
        mul_en    = 1'b1;
        state_nxt = L_DONE;
      end
      L_DONE: begin
        if (ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  assign prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;

  // target is truncated towards zero: divide the magnitude, then restore the sign
  assign quot     = prod_r[RECIP_SHIFT +: Q_W];
  assign quot_s   = $signed({1'b0, quot});
  assign tgt      = neg_r ? -quot_s : quot_s;
  assign err_calc = ERR_W'(tgt) - ERR_W'($signed({1'b0, meas_r}));

  assign pi_term = SUM_W'($signed(prod_r[PI_PROD_W-1:0]));
  assign sum     = acc_r + pi_term;
  assign po_sat  = (sum > ACC_MAX_EXT) ? ACC_MAX_EXT[ACC_W-1:0] :
                   (sum < ACC_MIN_EXT) ? ACC_MIN_EXT[ACC_W-1:0] : sum[ACC_W-1:0];

  assign lim     = {cfg.out_limit, {Q16{1'b0}}};
  assign po_ext  = SUM_W'(po_r);
  assign lim_ext = SUM_W'($signed({1'b0, lim}));

  assign duty_q  = prod_r[DUTY_SHIFT +: DUTY_Q_W];

  // integrator state, one copy in each lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      po_r <= '0;
      pe_r <= '0;
    end else if (state_r == L_SUM) begin
      po_r <= po_sat;
      pe_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && cmd.start) begin
      base_r   <= cmd.base;
      factor_r <= cmd.factor;
      meas_r   <= cmd.meas;
    end
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state_r == L_ABS) begin
      neg_r <= prod_r[PROD_W-1];
      mag_r <= prod_abs[Q16 +: MAG_W];
    end
    if (state_r == L_ERR) begin
      err_r <= err_calc;
    end
    if (state_r == L_MP) begin
      acc_r <= po_ext + pi_term;
    end
    if (state_r == L_CLAMP) begin
      if (po_ext < 0) begin
        clamp_r   <= '0;
        clamped_r <= 1'b1;
      end else if (po_ext > lim_ext) begin
        clamp_r   <= lim;
        clamped_r <= 1'b1;
      end else begin
        clamp_r   <= po_ext[CLAMP_W-1:0];
        clamped_r <= 1'b0;
      end
    end
  end

  assign res.done    = (state_r == L_DONE);
  assign res.duty    = (duty_q > DUTY_Q_W'(DUTY_MAX)) ? {DUTY_W{1'b1}} : duty_q[DUTY_W-1:0];
  assign res.clamped = clamped_r;

endmodule

// ----- dv/dwpi_duty_checker.sv -----
`timescale 1ns / 1ps

module dwpi_duty_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [dwpi_pkg::PEDAL_W-1:0]    in_pedal,
  input  logic [dwpi_pkg::STEER_W-1:0]    in_steering,
  input  logic [dwpi_pkg::SPEED_W-1:0]    in_speed_left,
  input  logic [dwpi_pkg::SPEED_W-1:0]    in_speed_right,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [dwpi_pkg::DUTY_W-1:0]     out_duty_left,
  input  logic [dwpi_pkg::DUTY_W-1:0]     out_duty_right,
  input  logic                            out_left_clamped,
  input  logic                            out_right_clamped,
  input  logic                            cfg_we,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwpi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);
  import dwpi_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_left;
    logic [DUTY_W-1:0] duty_right;
    logic              left_clamped;
    logic              right_clamped;
  } duty_result_t;

  localparam longint ACC_HI  = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO  = -ACC_HI - 1;
  localparam longint ERR_HI  = (longint'(1) <<< 23) - 1;
  localparam longint ERR_LO  = -ERR_HI - 1;
  localparam longint TGT_DIV = longint'(ONE_Q16) * PEDAL_FULL;

  longint tan_q16 [STEER_ROM_DEPTH];

  logic [SPD_LIM_W-1:0]     speed_limit_r;
  logic [RATIO_W-1:0]       ratio_r;
  logic signed [COEF_W-1:0] coef_cur_r;
  logic signed [COEF_W-1:0] coef_prev_r;
  logic [LIMIT_W-1:0]       out_limit_r;
  logic [GAIN_W-1:0]        duty_gain_r;

  // per wheel: unclamped integrator and last speed error, 0 is left
  longint integ [2];
  longint err_prev [2];

  duty_result_t expected_duty_q [$];
  duty_result_t want;
  int           mismatches = 0;

  // sin and cos by truncated Taylor series in Q30, quotient rounded to Q16
  function automatic longint steer_tangent_q16(input int code);
    int              cd;
    logic            below;
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t3;
    longint unsigned t5;
    longint unsigned t7;
    longint unsigned t9;
    longint unsigned sn;
    longint unsigned c2;
    longint unsigned c4;
    longint unsigned c6;
    longint unsigned c8;
    longint unsigned c10;
    longint unsigned cs;
    longint unsigned r;
    cd    = (code > TAN_CODE_MAX) ? TAN_CODE_MAX : code;
    below = (cd < CENTRE_CODE);
    m     = below ? longint'(CENTRE_CODE - cd) : longint'(cd - CENTRE_CODE);
    x     = m * longint'(ANGLE_STEP);
    x2    = (x * x) >> 30;
    t3    = ((x * x2) >> 30) / 64'd6;
    t5    = ((t3 * x2) >> 30) / 64'd20;
    t7    = ((t5 * x2) >> 30) / 64'd42;
    t9    = ((t7 * x2) >> 30) / 64'd72;
    sn    = x + t5 + t9 - t3 - t7;
    c2    = x2 / 64'd2;
    c4    = ((c2 * x2) >> 30) / 64'd12;
    c6    = ((c4 * x2) >> 30) / 64'd30;
    c8    = ((c6 * x2) >> 30) / 64'd56;
    c10   = ((c8 * x2) >> 30) / 64'd90;
    cs    = (64'd1 << 30) + c4 + c8 - c2 - c6 - c10;
    r     = ((sn << 16) + cs / 64'd2) / cs;
    return below ? -longint'(r) : longint'(r);
  endfunction

  function automatic void pi_wheel_step(input int k, input longint target,
                                        input longint meas,
                                        output logic [DUTY_W-1:0] duty,
                                        output logic clamped);
    longint e;
    longint u;
    longint lim;
    longint q;
    e = target - meas;
    if (e > ERR_HI) e = ERR_HI;
    if (e < ERR_LO) e = ERR_LO;
    // the step term stays well inside 64 bits, so saturating after the add is exact
    u = integ[k] + longint'(coef_cur_r) * e + longint'(coef_prev_r) * err_prev[k];
    if (u > ACC_HI) u = ACC_HI;
    if (u < ACC_LO) u = ACC_LO;
    integ[k]    = u;
    err_prev[k] = e;
    lim     = longint'(out_limit_r) <<< Q16;
    clamped = 1'b0;
    if (u < 0) begin
      u       = 0;
      clamped = 1'b1;
    end else if (u > lim) begin
      u       = lim;
      clamped = 1'b1;
    end
    q    = (u * longint'(duty_gain_r)) >>> DUTY_SHIFT;
    duty = (q > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : q[DUTY_W-1:0];
  endfunction

  function automatic duty_result_t predict_duty(input logic [PEDAL_W-1:0] pedal,
                                                input logic [STEER_W-1:0] steering,
                                                input logic [SPEED_W-1:0] meas_l,
                                                input logic [SPEED_W-1:0] meas_r);
    duty_result_t      res;
    int                p;
    int                idx;
    longint            delta;
    longint            base;
    longint            tgt_l;
    longint            tgt_r;
    logic [DUTY_W-1:0] dl;
    logic [DUTY_W-1:0] dr;
    logic              cl;
    logic              cr;
    p     = (pedal > PEDAL_FULL) ? PEDAL_FULL : int'(pedal);
    idx   = (steering >= STEER_ROM_DEPTH) ? STEER_ROM_DEPTH - 1 : int'(steering);
    delta = (longint'(ratio_r) * tan_q16[idx]) / ONE_Q16;
    base  = longint'(speed_limit_r) * p;
    tgt_l = base * (ONE_Q16 + delta) / TGT_DIV;
    tgt_r = base * (ONE_Q16 - delta) / TGT_DIV;
    pi_wheel_step(0, tgt_l, longint'(meas_l), dl, cl);
    pi_wheel_step(1, tgt_r, longint'(meas_r), dr, cr);
    res.duty_left     = dl;
    res.duty_right    = dr;
    res.left_clamped  = cl;
    res.right_clamped = cr;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  initial begin
    for (int i = 0; i < STEER_ROM_DEPTH; i++) tan_q16[i] = steer_tangent_q16(i);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r = SPEED_LIMIT_RST;
      ratio_r       = RATIO_RST;
      coef_cur_r    = COEF_CUR_RST;
      coef_prev_r   = COEF_PREV_RST;
      out_limit_r   = OUT_LIMIT_RST;
      duty_gain_r   = DUTY_GAIN_RST;
      integ[0]      = 0;
      integ[1]      = 0;
      err_prev[0]   = 0;
      err_prev[1]   = 0;
      expected_duty_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED_LIMIT:    speed_limit_r = cfg_wdata[SPD_LIM_W-1:0];
          REG_GEOMETRY_RATIO: ratio_r       = cfg_wdata[RATIO_W-1:0];
          REG_COEF_CURRENT:   coef_cur_r    = cfg_wdata[COEF_W-1:0];
          REG_COEF_PREVIOUS:  coef_prev_r   = cfg_wdata[COEF_W-1:0];
          REG_OUTPUT_LIMIT:   out_limit_r   = cfg_wdata[LIMIT_W-1:0];
          REG_DUTY_GAIN:      duty_gain_r   = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_duty_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, duty %0d/%0d clamp %0b/%0b",
                   $time, out_duty_left, out_duty_right, out_left_clamped,
                   out_right_clamped);
        end else begin
          want = expected_duty_q.pop_front();
          check_field("duty_left", want.duty_left, out_duty_left);
          check_field("duty_right", want.duty_right, out_duty_right);
          check_field("left_clamped", want.left_clamped, out_left_clamped);
          check_field("right_clamped", want.right_clamped, out_right_clamped);
        end
      end
      if (in_valid && in_ready) begin
        expected_duty_q.push_back(predict_duty(in_pedal, in_steering, in_speed_left,
                                               in_speed_right));
      end
    end
    fail_count  <= mismatches;
    outstanding <= expected_duty_q.size();
  end

endmodule

// ----- dv/dual_wheel_pi_speed_control_core_test.sv -----
`timescale 1ns / 1ps

module dual_wheel_pi_speed_control_core_test;
  import dwpi_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_TICKS  = 258;
  localparam int SETTLE_TICKS = 20;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PEDAL_W-1:0]    in_pedal;
  logic [STEER_W-1:0]    in_steering;
  logic [SPEED_W-1:0]    in_speed_left;
  logic [SPEED_W-1:0]    in_speed_right;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DUTY_W-1:0]     out_duty_left;
  logic [DUTY_W-1:0]     out_duty_right;
  logic                  out_left_clamped;
  logic                  out_right_clamped;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int cycles = 0;
  bit gaps_on = 1'b1;
  int cur_speed_limit = SPEED_LIMIT_RST;

  dual_wheel_pi_speed_control_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pedal          (in_pedal),
    .in_steering       (in_steering),
    .in_speed_left     (in_speed_left),
    .in_speed_right    (in_speed_right),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_left     (out_duty_left),
    .out_duty_right    (out_duty_right),
    .out_left_clamped  (out_left_clamped),
    .out_right_clamped (out_right_clamped),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  dwpi_duty_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pedal          (in_pedal),
    .in_steering       (in_steering),
    .in_speed_left     (in_speed_left),
    .in_speed_right    (in_speed_right),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_left     (out_duty_left),
    .out_duty_right    (out_duty_right),
    .out_left_clamped  (out_left_clamped),
    .out_right_clamped (out_right_clamped),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[dual_wheel_pi_speed_control_core] ERROR");
      $finish;
    end
  end

  task automatic send_tick(input int p, input int st, input int sl, input int sr);
    while (gaps_on && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pedal       <= PEDAL_W'(p);
    in_steering    <= STEER_W'(st);
    in_speed_left  <= SPEED_W'(sl);
    in_speed_right <= SPEED_W'(sr);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender off until every transfer in flight has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
  endtask

  task automatic write_regs(input int sl, input int ratio, input int cc, input int cp,
                            input int lim, input int gain);
    cfg_write(REG_SPEED_LIMIT, sl);
    cfg_write(REG_GEOMETRY_RATIO, ratio);
    cfg_write(REG_COEF_CURRENT, cc);
    cfg_write(REG_COEF_PREVIOUS, cp);
    cfg_write(REG_OUTPUT_LIMIT, lim);
    cfg_write(REG_DUTY_GAIN, gain);
    cfg_we <= 1'b0;
    cur_speed_limit = sl;
  endtask

  function automatic int speed_near(input int approx);
    int v;
    v = approx + int'($urandom_range(0, 400)) - 200;
    if (v < 0) v = 0;
    if (v > 2**SPEED_W - 1) v = 2**SPEED_W - 1;
    return v;
  endfunction

  // mostly speeds close to target so the integrators work inside the clamp
  task automatic random_tick();
    int p;
    int st;
    int approx;
    p = ($urandom_range(0, 15) == 0) ? $urandom_range(PEDAL_FULL + 1, 2**PEDAL_W - 1)
                                     : $urandom_range(0, PEDAL_FULL);
    if ($urandom_range(0, 3) == 0) st = $urandom_range(0, 2**STEER_W - 1);
    else st = CENTRE_CODE - 120 + int'($urandom_range(0, 240));
    approx = cur_speed_limit * ((p > PEDAL_FULL) ? PEDAL_FULL : p) / PEDAL_FULL;
    if ($urandom_range(0, 9) < 7) send_tick(p, st, speed_near(approx), speed_near(approx));
    else send_tick(p, st, $urandom_range(0, 2**SPEED_W - 1), $urandom_range(0, 2**SPEED_W - 1));
  endtask

  task automatic random_phase();
    repeat (PHASE_TICKS) random_tick();
    drain();
  endtask

  initial begin
    int cc;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pedal       <= '0;
    in_steering    <= '0;
    in_speed_left  <= '0;
    in_speed_right <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: zero tick, pedal over full, steering at both ends
    send_tick(0, CENTRE_CODE, 0, 0);
    send_tick(PEDAL_FULL, CENTRE_CODE, 5000, 5000);
    send_tick(PEDAL_FULL, CENTRE_CODE, 0, 16383);
    send_tick(1023, 0, 16383, 0);
    send_tick(1001, TAN_CODE_MAX, 100, 100);
    send_tick(500, 1800, 2500, 2500);
    send_tick(500, 1801, 2500, 2500);
    send_tick(500, CENTRE_CODE - 1, 2500, 2500);
    send_tick(500, CENTRE_CODE + 1, 2500, 2500);
    send_tick(0, TAN_CODE_MAX, 16383, 16383);
    send_tick(PEDAL_FULL, 1024, 4990, 5010);
    send_tick(PEDAL_FULL, CENTRE_CODE, 5000, 5000);
    send_tick(250, 600, 1200, 1300);
    send_tick(682, 1365, 10922, 5461);
    drain();

    // big ratio drives one target negative, zero limit clamps everything
    write_regs(16383, 131071, COEF_CUR_RST, COEF_PREV_RST, 0, 1048575);
    send_tick(PEDAL_FULL, TAN_CODE_MAX, 0, 0);
    send_tick(PEDAL_FULL, 0, 0, 0);
    send_tick(PEDAL_FULL, CENTRE_CODE, 16383, 16383);
    send_tick(1023, 1800, 8000, 8000);
    send_tick(0, CENTRE_CODE, 0, 0);
    send_tick(341, 682, 5461, 10922);
    drain();

    write_regs(SPEED_LIMIT_RST, RATIO_RST, COEF_CUR_RST, COEF_PREV_RST, OUT_LIMIT_RST,
               DUTY_GAIN_RST);
    random_phase();

    write_regs(16383, 131071, 8388607, 8388607, 1023, 1048575);
    random_phase();

    // no idling on either side for this whole setting
    gaps_on = 1'b0;
    write_regs(0, 0, -8388608, -8388608, 1, 0);
    random_phase();
    gaps_on = 1'b1;

    write_regs($urandom_range(0, 16383), $urandom_range(0, 131071),
               int'($urandom_range(0, 2**24 - 1)) - 2**23,
               int'($urandom_range(0, 2**24 - 1)) - 2**23,
               $urandom_range(1, 1023), $urandom_range(0, 2**20 - 1));
    random_phase();

    cc = $urandom_range(1000, 40000);
    write_regs($urandom_range(0, 16383), $urandom_range(0, 131071), cc,
               -int'($urandom_range(0, cc)), $urandom_range(1, 1023),
               $urandom_range(30000, 200000));
    random_phase();

    write_regs(SPEED_LIMIT_RST, RATIO_RST, COEF_CUR_RST, COEF_PREV_RST,
               $urandom_range(1, 1023), $urandom_range(0, 2**20 - 1));
    random_phase();

    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0) begin
      $display("[dual_wheel_pi_speed_control_core] OK");
    end else begin
      $display("[dual_wheel_pi_speed_control_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dwpi_pkg.sv
hdl/dwpi_rom.sv
hdl/dwpi_split.sv
hdl/dwpi_lane.sv
hdl/dual_wheel_pi_speed_control_core.sv
dv/dwpi_duty_checker.sv
dv/dual_wheel_pi_speed_control_core_test.sv
